// ===== hw/rtl/sdq_pkg.sv =====
// Shared types and constants for the sorted delay queue.
package sdq_pkg;

  localparam int unsigned DepthDefault = 16;
  localparam int unsigned MaxResults   = 16;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_RELEASED = 2'd1,
    STAT_DROPPED  = 2'd2,
    STAT_FULL     = 2'd3
  } status_t;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_TICK   = 1'b1
  } kind_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  task_id;
    logic [7:0]  priority_req;
    logic [15:0] delay;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] task_id_res;
    logic [7:0] priority_res;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  id;
    logic [7:0]  prio;
    logic [15:0] remaining;
  } entry_t;

endpackage

// ===== hw/rtl/sdq_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module sdq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/sorted_delay_queue_core.sv =====
// Sorted delay queue: pending tasks kept in RAM by ascending delay.
//
// Input channel (in_valid/in_stall/in_data) carries either an insert request
// (task id, priority, delay) or a timer tick. Result channel (out_valid/
// out_stall/out_data) returns one or more results per request, the final one
// marked by last.
// An insert gives one result: accepted, dropped (zero delay) or full. It
// walks the queue from the tail, reading each entry and moving it up one
// place while its delay exceeds the new delay.
// A tick walks every stored entry, reading each one, decrementing the
// delay, releasing expired head entries one result per entry and
// compacting the rest in place. A tick that releases nothing gives one
// accepted result.
// Requests are taken one at a time, only while the block is idle and the
// output register can be loaded. When the receiver stalls, the result is
// held in the output register and the walk waits on it.
// Reset empties the queue at once; RAM contents need no clearing.
module sorted_delay_queue_core
  import sdq_pkg::*;
#(
  parameter int unsigned DEPTH = DepthDefault
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_IRD, S_ICMP, S_INEW, S_IEMIT, S_TRD, S_TCHK, S_TEND
  } state_t;

  state_t         state_r;
  logic [CW-1:0]  count_r;
  logic [CW-1:0]  rel_r;
  logic [AW-1:0]  idx_r;
  logic           rel_open_r;
  logic           held_r;
  entry_t         held_entry_r;
  in_item_t       req_r;
  logic           out_valid_r;
  out_item_t      out_data_r;

  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  entry_t         ram_wdata;
  entry_t         ram_rdata;
  logic           out_free;
  logic           out_load;
  logic [15:0]    dec_rem;
  logic           rel_hit;
  logic           at_tail;
  entry_t         new_entry;

  sdq_ram #(.Width($bits(entry_t)), .Depth(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    out_free  = !out_valid_r || !out_stall;
    in_stall  = !((state_r == S_IDLE) && out_free);
    dec_rem   = (ram_rdata.remaining == 16'd0) ? 16'd0 : ram_rdata.remaining - 16'd1;
    rel_hit   = rel_open_r && (32'(rel_r) < MaxResults) && (dec_rem == 16'd0);
    at_tail   = ((CW'(idx_r) + CW'(1)) == count_r);
    new_entry = '{id: req_r.task_id, prio: req_r.priority_req, remaining: req_r.delay};
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = ram_rdata;
    unique case (state_r)
      S_ICMP: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r + AW'(1);
        ram_wdata = (ram_rdata.remaining > req_r.delay) ? ram_rdata : new_entry;
      end
      S_INEW: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = new_entry;
      end
      S_TCHK: begin
        // Survivors move down over the released head entries.
        ram_we    = !rel_hit && (!held_r || out_free);
        ram_waddr = AW'(CW'(idx_r) - rel_r);
        ram_wdata = '{id: ram_rdata.id, prio: ram_rdata.prio, remaining: dec_rem};
      end
      default: ;
    endcase
    // The output register takes a new result exactly where the state machine writes one.
    unique case (state_r)
      S_IDLE:  out_load = in_valid && !in_stall &&
                          ((in_data.kind == KIND_INSERT) ?
                           ((in_data.delay == 16'd0) || (count_r >= CW'(DEPTH))) :
                           (count_r == '0));
      S_IEMIT: out_load = out_free;
      S_TCHK:  out_load = held_r && out_free;
      S_TEND:  out_load = (held_r || (rel_r == '0)) && out_free;
      default: out_load = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      held_r      <= 1'b0;
      rel_open_r  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            req_r <= in_data;
            if (in_data.kind == KIND_INSERT) begin
              if (in_data.delay == 16'd0) begin
                out_data_r  <= '{status: STAT_DROPPED, task_id_res: '0,
                                 priority_res: '0, last: 1'b1};
              end else if (count_r >= CW'(DEPTH)) begin
                out_data_r  <= '{status: STAT_FULL, task_id_res: '0,
                                 priority_res: '0, last: 1'b1};
              end else if (count_r == '0) begin
                state_r <= S_INEW;
              end else begin
                idx_r   <= AW'(count_r - CW'(1));
                state_r <= S_IRD;
              end
            end else begin
              if (count_r == '0) begin
                out_data_r  <= '{status: STAT_OK, task_id_res: '0,
                                 priority_res: '0, last: 1'b1};
              end else begin
                idx_r      <= '0;
                rel_r      <= '0;
                rel_open_r <= 1'b1;
                held_r     <= 1'b0;
                state_r    <= S_TRD;
              end
            end
          end
        end
        S_IRD: state_r <= S_ICMP;
        S_ICMP: begin
          if (ram_rdata.remaining > req_r.delay) begin
            if (idx_r == '0) begin
              state_r <= S_INEW;
            end else begin
              idx_r   <= idx_r - AW'(1);
              state_r <= S_IRD;
            end
          end else begin
            state_r <= S_IEMIT;
          end
        end
        S_INEW: state_r <= S_IEMIT;
        S_IEMIT: begin
          if (out_free) begin
            out_data_r  <= '{status: STAT_OK, task_id_res: '0,
                             priority_res: '0, last: 1'b1};
            count_r     <= count_r + CW'(1);
            state_r     <= S_IDLE;
          end
        end
        S_TRD: state_r <= S_TCHK;
        S_TCHK: begin
          if (!held_r || out_free) begin
            // The held release goes out once we know whether another follows.
            if (held_r) begin
              out_data_r  <= '{status: STAT_RELEASED, task_id_res: held_entry_r.id,
                               priority_res: held_entry_r.prio, last: !rel_hit};
            end
            if (rel_hit) begin
              held_r       <= 1'b1;
              held_entry_r <= ram_rdata;
              rel_r        <= rel_r + CW'(1);
            end else begin
              held_r     <= 1'b0;
              rel_open_r <= 1'b0;
            end
            if (at_tail) begin
              state_r <= S_TEND;
            end else begin
              idx_r   <= idx_r + AW'(1);
              state_r <= S_TRD;
            end
          end
        end
        S_TEND: begin
          if (held_r || rel_r == '0) begin
            if (out_free) begin
              out_data_r  <= held_r ?
                  '{status: STAT_RELEASED, task_id_res: held_entry_r.id,
                    priority_res: held_entry_r.prio, last: 1'b1} :
                  '{status: STAT_OK, task_id_res: '0, priority_res: '0, last: 1'b1};
              held_r      <= 1'b0;
              count_r     <= count_r - rel_r;
              state_r     <= S_IDLE;
            end
          end else begin
            count_r <= count_r - rel_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH)) else $error("queue count exceeds depth");
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> (state_r == S_IDLE)) else $error("request taken while busy");
  a_rel_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TCHK) |-> (rel_r <= count_r)) else $error("release count exceeds count");
  a_no_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !held_r) else $error("release left pending in idle");
`endif

endmodule

// ===== tb/sv/sorted_delay_queue_core_test.sv =====
// Testbench for the sorted delay queue: random and directed requests checked against a predictor.
`timescale 1ns / 100ps

module sorted_delay_queue_core_test;
  import sdq_pkg::*;

  localparam int unsigned QDepth = DepthDefault;

  // Scoreboard: tracks the queue contents and the results they imply.
  class release_scoreboard;
    entry_t    pending[$];
    out_item_t expected_results[$];
    int        mismatches;

    function void note_request(in_item_t req);
      int unsigned pos;
      int unsigned released;
      out_item_t r;
      entry_t e;
      r = '0;
      r.last = 1'b1;
      if (req.kind == KIND_INSERT) begin
        if (req.delay == 16'd0) begin
          r.status = STAT_DROPPED;
        end else if (pending.size() >= QDepth) begin
          r.status = STAT_FULL;
        end else begin
          pos = 0;
          while (pos < pending.size() && pending[pos].remaining <= req.delay) pos++;
          e.id = req.task_id;
          e.prio = req.priority_req;
          e.remaining = req.delay;
          pending.insert(pos, e);
          r.status = STAT_OK;
        end
        expected_results.push_back(r);
      end else begin
        foreach (pending[i]) if (pending[i].remaining != 16'd0) pending[i].remaining--;
        released = 0;
        while (released < pending.size() && released < MaxResults &&
               pending[released].remaining == 16'd0) released++;
        if (released == 0) begin
          r.status = STAT_OK;
          expected_results.push_back(r);
        end else begin
          for (int unsigned k = 0; k < released; k++) begin
            e = pending.pop_front();
            r.status = STAT_RELEASED;
            r.task_id_res = e.id;
            r.priority_res = e.prio;
            r.last = (k + 1 == released);
            expected_results.push_back(r);
          end
        end
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_r;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      exp_r = expected_results.pop_front();
      if (got !== exp_r) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: expected st=%0d id=%0d pr=%0d last=%0d, ",
                   exp_r.status, exp_r.task_id_res, exp_r.priority_res, exp_r.last,
                   "got st=%0d id=%0d pr=%0d last=%0d",
                   got.status, got.task_id_res, got.priority_res, got.last);
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  release_scoreboard sb;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  sorted_delay_queue_core #(.DEPTH(QDepth)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Receiver: stalls at random and checks every accepted result.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Valid stays high after acceptance until the next request or an idle cycle replaces it.
  task automatic send_request(in_item_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(req);
  endtask

  task automatic send_insert(logic [7:0] id, logic [7:0] pr, logic [15:0] dl);
    in_item_t req;
    req.kind = KIND_INSERT;
    req.task_id = id;
    req.priority_req = pr;
    req.delay = dl;
    send_request(req);
  endtask

  task automatic send_tick();
    in_item_t req;
    req = in_item_t'({1'($urandom), $urandom});
    req.kind = KIND_TICK;
    send_request(req);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
  endtask

  // Mostly small delays so that tasks expire; sometimes any value.
  task automatic random_request();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 40) send_tick();
    else if (pick < 85) send_insert(8'($urandom), 8'($urandom), 16'($urandom_range(1, 6)));
    else if (pick < 92) send_insert(8'($urandom), 8'($urandom), 16'($urandom));
    else if (pick < 96) send_insert(8'($urandom), 8'($urandom), 16'd0);
    else send_request(in_item_t'({1'($urandom), $urandom}));
  endtask

  initial begin
    #2_000_000;
    $display("sorted_delay_queue_core test failed");
    $finish;
  end

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    send_idle_pct = 12;
    recv_idle_pct = 71;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty tick, zero delay, field extremes, ties, full queue, big burst.
    send_tick();
    send_insert(8'hFF, 8'hFF, 16'd0);
    send_insert(8'h00, 8'h00, 16'hFFFF);
    send_insert(8'hFF, 8'hFF, 16'd1);
    send_insert(8'hA5, 8'h5A, 16'd1);
    send_tick();
    for (int i = 0; i < 16; i++) send_insert(8'(i), 8'(255 - i), 16'd2);
    send_insert(8'h77, 8'h88, 16'd1);
    send_tick();
    send_tick();
    send_tick();
    wait_drained();

    for (int n = 0; n < 370; n++) begin
      if (n == 120) begin
        send_idle_pct = 71;
        recv_idle_pct = 12;
      end
      if (n == 240) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (n == 300) wait_drained();
      random_request();
    end

    wait_drained();
    repeat (100) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
      $display("sorted_delay_queue_core test passed");
    end else begin
      $display("sorted_delay_queue_core test failed");
    end
    $finish;
  end

endmodule

// ===== sorted_delay_queue_core.f =====
hw/rtl/sdq_pkg.sv
hw/rtl/sdq_ram.sv
hw/rtl/sorted_delay_queue_core.sv
tb/sv/sorted_delay_queue_core_test.sv
